// ===== hw/rtl/tlrq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types, constants and helpers of the three-level ready queue.
// ----------------------------------------------------------------------------
package tlrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int THREAD_W = 8;
    localparam int PRIO_W   = 8;
    localparam int BURST_W  = 32;
    localparam int TICKS_W  = 28;
    localparam int FRAC_W   = 4;
    localparam int REM_W    = BURST_W + 2;
    localparam int LEVEL_W  = 2;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    localparam logic [PRIO_W-1:0] MID_RESET = 8'd50;
    localparam logic [PRIO_W-1:0] TOP_RESET = 8'd100;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MID  = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd3;

    localparam logic REG_MID = 1'b0;
    localparam logic REG_TOP = 1'b1;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_PICK   = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REMOVE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [THREAD_W-1:0]     thread;
        logic [LEVEL_W-1:0]      level;
        logic [PRIO_W-1:0]       prio;
        logic signed [REM_W-1:0] remaining;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [LEVEL_W-1:0]  level;
        logic [THREAD_W-1:0] thread;
    } pick_t;

    function automatic logic [LEVEL_W-1:0] level_of(
        input logic [PRIO_W-1:0] prio,
        input logic [PRIO_W-1:0] mid_min,
        input logic [PRIO_W-1:0] top_min
    );
        logic [LEVEL_W-1:0] lvl;
        if (prio < mid_min) begin
            lvl = LEVEL_LOW;
        end else if (prio < top_min) begin
            lvl = LEVEL_MID;
        end else begin
            lvl = LEVEL_TOP;
        end
        return lvl;
    endfunction

    function automatic logic signed [REM_W-1:0] remaining_of(
        input logic [BURST_W-1:0] burst,
        input logic [TICKS_W-1:0] ticks
    );
        logic [REM_W-1:0] diff;
        diff = REM_W'(burst) - REM_W'({ticks, {FRAC_W{1'b0}}});
        return $signed(diff);
    endfunction

endpackage

// ===== hw/rtl/tlrq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_cell
// One slot of the queue chain: loads an inserted thread when it is the first
// free slot, takes its upper neighbor while rotating or closing a gap.
// ----------------------------------------------------------------------------
module tlrq_cell
    import tlrq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl_i,
    input  entry_t     new_i,
    input  logic       prev_valid_i,
    input  logic       shift_i,
    input  logic       nbr_valid_i,
    input  entry_t     nbr_i,
    output logic       valid_o,
    output entry_t     entry_o
);

    logic   valid_reg, valid_next;
    entry_t data_reg, data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl_i.rotate || shift_i) begin
            valid_next = nbr_valid_i;
            data_next  = nbr_i;
        end else if (ctrl_i.insert && !valid_reg && prev_valid_i) begin
            valid_next = 1'b1;
            data_next  = new_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid_o = valid_reg;
    assign entry_o = data_reg;

endmodule

// ===== hw/rtl/tlrq_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrq_scan
// Watches the chain head while the ring rotates and keeps the best thread
// seen: top level first, then least remaining burst (top), highest prio (mid).
// ----------------------------------------------------------------------------
module tlrq_scan
    import tlrq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear_i,
    input  logic             step_i,
    input  logic [IDX_W-1:0] idx_i,
    input  logic             valid_i,
    input  entry_t           entry_i,
    output pick_t            pick_o
);

    logic             found_reg, found_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    entry_t           best_reg, best_next;
    logic             better;

    always_comb begin
        better = 1'b0;
        if (valid_i) begin
            if (!found_reg || (entry_i.level < best_reg.level)) begin
                better = 1'b1;
            end else if (entry_i.level == best_reg.level) begin
                if (entry_i.level == LEVEL_TOP) begin
                    better = $signed(entry_i.remaining) < $signed(best_reg.remaining);
                end else if (entry_i.level == LEVEL_MID) begin
                    better = entry_i.prio > best_reg.prio;
                end
            end
        end
    end

    always_comb begin
        found_next = found_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        if (clear_i) begin
            found_next = 1'b0;
        end else if (step_i && better) begin
            found_next = 1'b1;
            idx_next   = idx_i;
            best_next  = entry_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        best_reg <= best_next;
    end

    assign pick_o.idx    = idx_reg;
    assign pick_o.level  = best_reg.level;
    assign pick_o.thread = best_reg.thread;

endmodule

// ===== hw/rtl/three_level_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_ready_queue
// Ready queue of up to QUEUE_DEPTH threads in three levels, held in a chain
// of cells in arrival order.
//
// s_ beats carry one command: s_tuser selects insert or pick, s_tdata the
// thread fields. Every command gives exactly one m_ beat: m_tuser is the
// status, m_tdata the picked thread and its level.
// An insert lands in the first free cell in the cycle it is accepted; its
// result goes from the response state into the output register, and no new
// command is taken before that. A pick rotates the whole chain once past the
// head, one cell a cycle, while a scanner keeps the best candidate; the
// remove state then closes the gap and the response state loads the result.
// A pick on an empty queue answers like an insert.
// One command is in work at a time. A finished result sits in the output
// register; the next command is accepted meanwhile and its result waits
// until the receiver takes the previous one, holding off further commands.
// Reset empties the queue and loads the thresholds 50 and 100.
// The APB port holds the two thresholds; write them only while idle.
// ----------------------------------------------------------------------------
module three_level_ready_queue
    import tlrq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // apb configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // command stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // thread_id, thread_prio, burst_estimate, ticks_run, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command
    input  logic [0:0]           s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // picked_thread, picked_level, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser
);

    // configuration
    logic [PRIO_W-1:0] mid_reg, top_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg <= MID_RESET;
            top_reg <= TOP_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_MID) begin
                mid_reg <= pwdata[PRIO_W-1:0];
            end else begin
                top_reg <= pwdata[PRIO_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MID) ? 32'(mid_reg) : 32'(top_reg);

    // input beat fields
    cmd_t               in_cmd;
    logic [THREAD_W-1:0] in_thread;
    logic [PRIO_W-1:0]   in_prio;
    logic [BURST_W-1:0]  in_burst;
    logic [TICKS_W-1:0]  in_ticks;
    entry_t              new_entry;

    assign in_cmd    = cmd_t'(s_tuser[0]);
    assign in_thread = s_tdata[7:0];
    assign in_prio   = s_tdata[15:8];
    assign in_burst  = s_tdata[47:16];
    assign in_ticks  = s_tdata[75:48];

    assign new_entry.thread    = in_thread;
    assign new_entry.level     = level_of(in_prio, mid_reg, top_reg);
    assign new_entry.prio      = in_prio;
    assign new_entry.remaining = remaining_of(in_burst, in_ticks);

    // control
    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             res_status_reg, res_status_next;
    logic [THREAD_W-1:0] res_thread_reg, res_thread_next;
    logic [LEVEL_W-1:0]  res_level_reg, res_level_next;
    cell_ctrl_t          ctrl;
    logic                scan_clear, scan_step, remove, load_out;
    pick_t               pick;

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_thread_next = res_thread_reg;
        res_level_next  = res_level_reg;
        ctrl            = '0;
        scan_clear      = 1'b0;
        scan_step       = 1'b0;
        remove          = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_thread_next = '0;
                    res_level_next  = LEVEL_NONE;
                    if (in_cmd == CMD_INSERT) begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            ctrl.insert     = 1'b1;
                            count_next      = count_reg + CNT_W'(1);
                            res_status_next = STATUS_OK;
                        end
                        state_next = ST_RESP;
                    end else if (count_reg == '0) begin
                        res_status_next = STATUS_EMPTY;
                        state_next      = ST_RESP;
                    end else begin
                        scan_clear = 1'b1;
                        step_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                ctrl.rotate = 1'b1;
                scan_step   = 1'b1;
                step_next   = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(QUEUE_DEPTH - 1)) begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE: begin
                remove          = 1'b1;
                count_next      = count_reg - CNT_W'(1);
                res_status_next = STATUS_OK;
                res_thread_next = pick.thread;
                res_level_next  = pick.level;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (!m_tvalid || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_thread_reg <= res_thread_next;
        res_level_reg  <= res_level_next;
    end

    // output register
    logic                m_valid_reg;
    status_t             out_status_reg;
    logic [THREAD_W-1:0] out_thread_reg;
    logic [LEVEL_W-1:0]  out_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_status_reg <= res_status_reg;
            out_thread_reg <= res_thread_reg;
            out_level_reg  <= res_level_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = M_TDATA_W'({out_level_reg, out_thread_reg});

    // cell chain
    logic   valid_w [QUEUE_DEPTH];
    entry_t entry_w [QUEUE_DEPTH];
    logic   last_nbr_valid;

    // rotation wraps the head around, closing a gap pulls in an empty slot
    assign last_nbr_valid = ctrl.rotate ? valid_w[0] : 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   prev_valid, nbr_valid, shift;
        entry_t nbr;

        if (i == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_prev
            assign prev_valid = valid_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nbr_valid = last_nbr_valid;
            assign nbr       = entry_w[0];
        end else begin : g_next
            assign nbr_valid = valid_w[i+1];
            assign nbr       = entry_w[i+1];
        end

        assign shift = remove && (pick.idx <= IDX_W'(i));

        tlrq_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctrl_i       (ctrl),
            .new_i        (new_entry),
            .prev_valid_i (prev_valid),
            .shift_i      (shift),
            .nbr_valid_i  (nbr_valid),
            .nbr_i        (nbr),
            .valid_o      (valid_w[i]),
            .entry_o      (entry_w[i])
        );
    end

    tlrq_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear_i (scan_clear),
        .step_i  (scan_step),
        .idx_i   (step_reg),
        .valid_i (valid_w[0]),
        .entry_i (entry_w[0]),
        .pick_o  (pick)
    );

endmodule
